[rtl/core/ect_pkg.sv]
// ----------------------------------------------------------------------------
// ect_pkg
// Shared types and constants of the edge coverage tracer: command codes,
// draw sequencing codes, generator constants and the draw request bundle.
// ----------------------------------------------------------------------------
package ect_pkg;

  // Command codes on the cmd port
  localparam logic [1:0] CMD_TRACE      = 2'd0;
  localparam logic [1:0] CMD_INIT_FIRST = 2'd1;
  localparam logic [1:0] CMD_INIT_NEXT  = 2'd2;
  localparam logic [1:0] CMD_READ       = 2'd3;

  // Configuration register indexes
  localparam logic REG_PRNG_SEED = 1'b0;
  localparam logic REG_ID_RATIO  = 1'b1;

  // Field widths
  localparam int SEED_W  = 48;
  localparam int RATIO_W = 7;
  localparam int ID_W    = 16;
  localparam int COUNT_W = 8;

  // Generator: state' = (0x5DEECE66D * state + 11) mod 2^48
  localparam logic [23:0]     LCG_MUL_LO = 24'hECE66D;
  localparam logic [10:0]     LCG_MUL_HI = 11'h5DE;
  localparam logic [SEED_W-1:0] LCG_ADD  = 48'd11;

  localparam logic [RATIO_W-1:0] RATIO_MOD   = 7'd100;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 7'd100;

  // Which draw of an init sequence is under way
  typedef enum logic [1:0] {
    K_PREV  = 2'd0,
    K_FIRST = 2'd1,
    K_RATIO = 2'd2,
    K_NEXT  = 2'd3
  } draw_kind_t;

  // Request to the draw unit
  typedef struct packed {
    logic go;         // start one draw
    logic load;       // load the seed into the generator state
    logic use_ratio;  // reduce modulo 100 instead of 2^MAP_BITS - 1
  } draw_req_t;

endpackage

[rtl/core/ect_draw.sv]
// ----------------------------------------------------------------------------
// ect_draw
// Random draw unit: 48-bit linear congruential step on one shared 24x24
// multiplier (D_MUL0..D_MUL2), then reduction (D_RED0, D_RED1) on the upper
// 32 bits: reciprocal multiplication for modulo 100, chunk folding for
// modulo 2^MAP_BITS - 1. done pulses for one cycle with rem valid.
// ----------------------------------------------------------------------------
module ect_draw #(
  parameter int MAP_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ect_pkg::draw_req_t    req,
  input  logic [47:0]           seed,
  output logic [MAP_BITS-1:0]   rem,
  output logic                  done
);
  import ect_pkg::*;

  // Number of MAP_BITS-wide chunks in a 32-bit draw
  localparam int NCHUNK = (32 + MAP_BITS - 1) / MAP_BITS;
  // floor(r / 100) = (r * ceil(2^37 / 100)) >> 37 for every 32-bit r
  localparam logic [43:0] RECIP_100 = 44'h0_51EB_851F;
  localparam logic [MAP_BITS:0] ID_MOD = {1'b0, {MAP_BITS{1'b1}}};

  typedef enum logic [5:0] {
    D_IDLE = 6'b000001,
    D_MUL0 = 6'b000010,
    D_MUL1 = 6'b000100,
    D_MUL2 = 6'b001000,
    D_RED0 = 6'b010000,
    D_RED1 = 6'b100000
  } dstate_t;

  dstate_t               state;
  logic [SEED_W-1:0]     lcg;
  logic [SEED_W-1:0]     acc;
  logic [31:0]           draw_bits;
  logic [RATIO_W-1:0]    quot_lo;
  logic [MAP_BITS+1:0]   chunk_q;
  logic                  use_ratio;

  logic [23:0]           mul_a;
  logic [23:0]           mul_b;
  logic [47:0]           prod;
  logic [SEED_W-1:0]     sum;
  logic [SEED_W-1:0]     lcg_next;
  logic [43:0]           recip_prod;
  logic [31:0]           shifted;
  logic [MAP_BITS+1:0]   chunk_sum;
  logic [MAP_BITS:0]     fold;
  logic [MAP_BITS-1:0]   id_rem;
  logic [RATIO_W-1:0]    ratio_rem;

  // Shared multiplier: lo*lo, lo*hi, hi*lo partial products
  always_comb begin
    mul_a    = (state == D_MUL2) ? lcg[47:24] : lcg[23:0];
    mul_b    = (state == D_MUL1) ? 24'(LCG_MUL_HI) : LCG_MUL_LO;
    prod     = mul_a * mul_b;
    sum      = acc + {prod[23:0], 24'b0};
    lcg_next = sum + LCG_ADD;
  end

  // First reduction cycle: quotient by 100 (low bits kept) and chunk sum,
  // since 2^MAP_BITS is 1 modulo 2^MAP_BITS - 1
  always_comb begin
    recip_prod = 44'(draw_bits) * RECIP_100;
    chunk_sum  = '0;
    shifted    = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      shifted   = draw_bits >> (i * MAP_BITS);
      chunk_sum = chunk_sum + {2'b00, shifted[MAP_BITS-1:0]};
    end
  end

  // Second reduction cycle: remainder by 100 fits in 7 bits, so it is
  // worked out modulo 128; the chunk sum is folded once and corrected
  always_comb begin
    ratio_rem = draw_bits[RATIO_W-1:0] - 7'(quot_lo * RATIO_MOD);
    fold      = {1'b0, chunk_q[MAP_BITS-1:0]}
              + (MAP_BITS+1)'(chunk_q[MAP_BITS+1:MAP_BITS]);
    id_rem    = (fold >= ID_MOD) ? MAP_BITS'(fold - ID_MOD) : fold[MAP_BITS-1:0];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: if (req.go) state <= D_MUL0;
        D_MUL0: state <= D_MUL1;
        D_MUL1: state <= D_MUL2;
        D_MUL2: state <= D_RED0;
        D_RED0: state <= D_RED1;
        D_RED1: begin
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.load) lcg <= seed;
    case (state)
      D_IDLE: if (req.go) use_ratio <= req.use_ratio;
      D_MUL0: acc <= prod;
      D_MUL1: acc <= sum;
      D_MUL2: begin
        lcg       <= lcg_next;
        draw_bits <= lcg_next[47:16];
      end
      D_RED0: begin
        quot_lo <= recip_prod[43:37];
        chunk_q <= chunk_sum;
      end
      D_RED1: rem <= use_ratio ? MAP_BITS'(ratio_rem) : id_rem;
      default: ;
    endcase
  end

endmodule

[rtl/core/edge_coverage_tracer_unit.sv]
// ----------------------------------------------------------------------------
// edge_coverage_tracer_unit
// Edge coverage hit map with random guard id allocation.
//
// A command is transferred at a clock edge with start high and busy low:
// cmd, guard_value and map_index are sampled there. Each command gives one
// result on assigned_id, hit_count and skipped, marked by done for one
// cycle; the receiver cannot stall it.
// Trace and map read: the map RAM is read at the transfer, a trace writes
// back in S_MAP, and the result follows in the cycle after S_MAP.
// Commands that have no effect: result in the next cycle, one per cycle.
// Init next: one draw against the id ratio, and a second draw for the id when
// it falls below the ratio. Init first: two draws, for last_loc and the id.
// Each draw runs through the shared multiplier, the reduction and done.
// Reset: a clearing pass writes zero to all 2^MAP_BITS map bytes, one per
// cycle, with busy high; configuration writes are taken during it. The user
// writes configuration (cfg_we, cfg_index, cfg_data) while idle; not enforced.
// ----------------------------------------------------------------------------
module edge_coverage_tracer_unit #(
  parameter int MAP_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd,
  input  logic [15:0]                  guard_value,
  input  logic [15:0]                  map_index,
  output logic                         done,
  output logic [ect_pkg::ID_W-1:0]     assigned_id,
  output logic [ect_pkg::COUNT_W-1:0]  hit_count,
  output logic                         skipped,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [ect_pkg::SEED_W-1:0]   cfg_data
);
  import ect_pkg::*;

  localparam int MAP_DEPTH = 1 << MAP_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CLEAR = 4'b0010,
    S_MAP   = 4'b0100,
    S_DRAW  = 4'b1000
  } state_t;

  state_t                state;
  logic [MAP_BITS-1:0]   clr_addr;
  logic [ID_W-1:0]       last_loc;
  logic                  map_active;
  logic [SEED_W-1:0]     prng_seed;
  logic [RATIO_W-1:0]    ratio_pct;
  logic [1:0]            cmd_q;
  logic [MAP_BITS-1:0]   addr_q;
  draw_kind_t            kind;

  // Hit map
  logic [COUNT_W-1:0]    hit_map [MAP_DEPTH];
  logic [COUNT_W-1:0]    rd_data;
  logic [MAP_BITS-1:0]   rd_addr;
  logic                  wr_en;
  logic [MAP_BITS-1:0]   wr_addr;
  logic [COUNT_W-1:0]    wr_data;
  logic [COUNT_W-1:0]    bumped;

  logic                  accept;
  draw_req_t             dreq;
  logic [MAP_BITS-1:0]   draw_rem;
  logic                  draw_done;
  logic                  rem_lt_ratio;
  logic [MAP_BITS:0]     id_full;
  logic [ID_W-1:0]       id_val;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign bumped = rd_data + COUNT_W'(1);

  // Map addressing and write-back
  always_comb begin
    rd_addr = (cmd == CMD_READ) ? MAP_BITS'(map_index)
                                : MAP_BITS'(guard_value ^ last_loc);
    wr_en   = (state == S_CLEAR) || ((state == S_MAP) && (cmd_q == CMD_TRACE));
    wr_addr = (state == S_CLEAR) ? clr_addr : addr_q;
    wr_data = (state == S_CLEAR) ? '0 : bumped;
  end

  always_ff @(posedge clk) begin
    if (wr_en) hit_map[wr_addr] <= wr_data;
    rd_data <= hit_map[rd_addr];
  end

  // Draw results
  always_comb begin
    rem_lt_ratio = (draw_rem < MAP_BITS'(ratio_pct));
    id_full      = {1'b0, draw_rem} + (MAP_BITS+1)'(1);
    id_val       = ID_W'(id_full);
  end

  // Draw requests: on init transfer, and chained second draws
  always_comb begin
    dreq.load      = accept && (cmd == CMD_INIT_FIRST) && (guard_value == '0);
    dreq.use_ratio = accept && (cmd == CMD_INIT_NEXT);
    dreq.go        = dreq.load
                  || (accept && (cmd == CMD_INIT_NEXT) && map_active)
                  || ((state == S_DRAW) && draw_done
                      && ((kind == K_PREV) || ((kind == K_RATIO) && rem_lt_ratio)));
  end

  ect_draw #(
    .MAP_BITS (MAP_BITS)
  ) u_draw (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .seed (prng_seed),
    .rem  (draw_rem),
    .done (draw_done)
  );

  // Command sequencer, result register and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      last_loc    <= '0;
      map_active  <= 1'b0;
      prng_seed   <= '0;
      ratio_pct   <= RATIO_RESET;
      done        <= 1'b0;
      assigned_id <= '0;
      hit_count   <= '0;
      skipped     <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_PRNG_SEED: prng_seed <= cfg_data;
          REG_ID_RATIO:  ratio_pct <= cfg_data[RATIO_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + MAP_BITS'(1);
          if (&clr_addr) state <= S_IDLE;
        end

        S_IDLE: begin
          if (accept) begin
            cmd_q  <= cmd;
            addr_q <= rd_addr;
            case (cmd)
              CMD_TRACE: begin
                if (map_active && (guard_value != '0)) begin
                  last_loc <= guard_value >> 1;
                  state    <= S_MAP;
                end else begin
                  done        <= 1'b1;
                  assigned_id <= '0;
                  hit_count   <= '0;
                  skipped     <= 1'b1;
                end
              end
              CMD_INIT_FIRST: begin
                if (guard_value != '0) begin
                  done        <= 1'b1;
                  assigned_id <= '0;
                  hit_count   <= '0;
                  skipped     <= 1'b1;
                end else begin
                  map_active <= 1'b1;
                  kind       <= K_PREV;
                  state      <= S_DRAW;
                end
              end
              CMD_INIT_NEXT: begin
                if (!map_active) begin
                  done        <= 1'b1;
                  assigned_id <= '0;
                  hit_count   <= '0;
                  skipped     <= 1'b1;
                end else begin
                  kind  <= K_RATIO;
                  state <= S_DRAW;
                end
              end
              default: state <= S_MAP;
            endcase
          end
        end

        // Read data is back: a trace writes back in this cycle
        S_MAP: begin
          done        <= 1'b1;
          assigned_id <= '0;
          hit_count   <= (cmd_q == CMD_TRACE) ? bumped : rd_data;
          skipped     <= 1'b0;
          state       <= S_IDLE;
        end

        S_DRAW: begin
          if (draw_done) begin
            case (kind)
              K_PREV: begin
                last_loc <= id_val;
                kind     <= K_FIRST;
              end
              K_RATIO: begin
                if (rem_lt_ratio) begin
                  kind <= K_NEXT;
                end else begin
                  done        <= 1'b1;
                  assigned_id <= '0;
                  hit_count   <= '0;
                  skipped     <= 1'b0;
                  state       <= S_IDLE;
                end
              end
              default: begin
                done        <= 1'b1;
                assigned_id <= id_val;
                hit_count   <= '0;
                skipped     <= 1'b0;
                state       <= S_IDLE;
              end
            endcase
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
